### rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // Default number of fraction bits of every element and result.
  localparam int FRAC_BITS_DEF = 14;

  // Widths of the matrix elements and the quaternion components.
  localparam int MAT_W  = 16;
  localparam int QUAT_W = 16;

  // Sum or difference of two elements.
  localparam int DIFF_W = MAT_W + 1;

  // Quotient bits resolved by the divider; larger quotients saturate.
  localparam int QUO_BITS = QUAT_W;

  // Branch codes, also sent out as the pivot branch.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M00   = 2'd1,
    BR_M11   = 2'd2,
    BR_M22   = 2'd3
  } branch_t;

  // Sideband that travels with each request down the pipeline.
  typedef struct packed {
    logic                      valid;
    branch_t                   br;
    logic                      zero;
    logic signed [DIFF_W-1:0]  n0;
    logic signed [DIFF_W-1:0]  n1;
    logic signed [DIFF_W-1:0]  n2;
  } side_t;

endpackage

`default_nettype wire

### rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_if
// Request channels: the matrix input channel and the quaternion result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_mat_if import rmq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [MAT_W-1:0]  m00;
  logic signed [MAT_W-1:0]  m01;
  logic signed [MAT_W-1:0]  m02;
  logic signed [MAT_W-1:0]  m10;
  logic signed [MAT_W-1:0]  m11;
  logic signed [MAT_W-1:0]  m12;
  logic signed [MAT_W-1:0]  m20;
  logic signed [MAT_W-1:0]  m21;
  logic signed [MAT_W-1:0]  m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [QUAT_W-1:0]  quat_w;
  logic signed [QUAT_W-1:0]  quat_x;
  logic signed [QUAT_W-1:0]  quat_y;
  logic signed [QUAT_W-1:0]  quat_z;
  logic [1:0]                pivot_branch;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, pivot_branch,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, pivot_branch,
                  output ready);
endinterface

`default_nettype wire

### rtl/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a 3x3 rotation matrix to a unit quaternion by the largest-pivot
// method, in signed fixed point with saturated results.
// ----------------------------------------------------------------------------
//
//   Channel   Port      Direction  Carries
//   input     in_mat    sink       m00..m22, one matrix per request
//   result    out_quat  source     quat_w/x/y/z and pivot_branch
//
// One matrix may enter every cycle while the output is not held. The
// pipeline has one front stage, one stage per root bit in the square
// root pipeline, one prep and sixteen bit stages in the divider, one output.
// Reset clears only the valid bits. When a result waits on the output, the
// whole pipeline holds and in_mat.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmq_mat_if.sink     in_mat,
  rmq_quat_if.source  out_quat
);

  localparam int F  = FRACTION_BITS;
  localparam int AW = (F > 17) ? F + 2 : 19;
  localparam int SQ = (AW + F - 2) / 2;
  localparam int VW = 2 * SQ;
  localparam int SW = SQ + QUAT_W;

  localparam logic signed [QUAT_W-1:0] Q_MAX = {1'b0, {(QUAT_W-1){1'b1}}};
  localparam logic signed [QUAT_W-1:0] Q_MIN = {1'b1, {(QUAT_W-1){1'b0}}};

  logic adv;
  logic out_valid_r;

  // The pipeline moves whenever the output register is free or drained.
  assign adv          = !out_valid_r || out_quat.ready;
  assign in_mat.ready = adv;

  // Front stage: branch choice, pivot argument and off-diagonal terms.
  logic signed [AW-1:0] e00, e11, e22, one_s, trace, a_val;
  side_t                front_nxt, front_r;
  logic [VW-1:0]        v_nxt, v_r;

  always_comb begin
    e00   = AW'(in_mat.m00);
    e11   = AW'(in_mat.m11);
    e22   = AW'(in_mat.m22);
    one_s = AW'(1) <<< F;
    trace = e00 + e11 + e22;
    front_nxt.valid = in_mat.valid;
    if (trace > 0) begin
      front_nxt.br = BR_TRACE;
      a_val        = one_s + trace;
      front_nxt.n0 = DIFF_W'(in_mat.m21) - DIFF_W'(in_mat.m12);
      front_nxt.n1 = DIFF_W'(in_mat.m02) - DIFF_W'(in_mat.m20);
      front_nxt.n2 = DIFF_W'(in_mat.m10) - DIFF_W'(in_mat.m01);
    end else if (e00 > e11 && e00 > e22) begin
      front_nxt.br = BR_M00;
      a_val        = one_s + e00 - e11 - e22;
      front_nxt.n0 = DIFF_W'(in_mat.m21) - DIFF_W'(in_mat.m12);
      front_nxt.n1 = DIFF_W'(in_mat.m01) + DIFF_W'(in_mat.m10);
      front_nxt.n2 = DIFF_W'(in_mat.m02) + DIFF_W'(in_mat.m20);
    end else if (e11 > e22) begin
      front_nxt.br = BR_M11;
      a_val        = one_s + e11 - e00 - e22;
      front_nxt.n0 = DIFF_W'(in_mat.m02) - DIFF_W'(in_mat.m20);
      front_nxt.n1 = DIFF_W'(in_mat.m01) + DIFF_W'(in_mat.m10);
      front_nxt.n2 = DIFF_W'(in_mat.m12) + DIFF_W'(in_mat.m21);
    end else begin
      front_nxt.br = BR_M22;
      a_val        = one_s + e22 - e00 - e11;
      front_nxt.n0 = DIFF_W'(in_mat.m10) - DIFF_W'(in_mat.m01);
      front_nxt.n1 = DIFF_W'(in_mat.m02) + DIFF_W'(in_mat.m20);
      front_nxt.n2 = DIFF_W'(in_mat.m12) + DIFF_W'(in_mat.m21);
    end
    front_nxt.zero = (a_val <= 0);
    v_nxt = front_nxt.zero ? '0 : (VW'(a_val[AW-2:0]) << (F - 2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (adv) begin
      front_r <= front_nxt;
      v_r     <= v_nxt;
    end
  end

  // Square root of the pivot argument.
  side_t         sq_side;
  logic [SQ-1:0] sq_root;

  rmq_isqrt #(
    .SQ (SQ)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_side  (front_r),
    .in_v     (v_r),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // Divide the three off-diagonal terms by four times the pivot.
  side_t               dv_side;
  logic [SQ-1:0]       dv_p;
  logic [QUO_BITS-1:0] dv_q   [3];
  logic                dv_neg [3];
  logic                dv_ovf [3];

  rmq_div #(
    .F  (F),
    .SQ (SQ)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_side  (sq_side),
    .in_p     (sq_root),
    .out_side (dv_side),
    .out_p    (dv_p),
    .out_q    (dv_q),
    .out_neg  (dv_neg),
    .out_ovf  (dv_ovf)
  );

  // Saturate the quotients and the pivot, then place them by branch.
  logic signed [QUAT_W-1:0] o_sat [3];
  logic signed [QUAT_W-1:0] p_sat;
  logic signed [QUAT_W-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  branch_t                  br_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!dv_neg[l]) begin
        o_sat[l] = (dv_ovf[l] || dv_q[l][QUO_BITS-1]) ? Q_MAX : dv_q[l];
      end else begin
        o_sat[l] = (dv_ovf[l] || dv_q[l] > QUO_BITS'(Q_MIN)) ? Q_MIN
                                                             : (~dv_q[l] + QUO_BITS'(1));
      end
    end
    p_sat = (SW'(dv_p) > SW'(Q_MAX)) ? Q_MAX : QUAT_W'(dv_p);
    case (dv_side.br)
      BR_TRACE: begin
        qw_nxt = p_sat;    qx_nxt = o_sat[0]; qy_nxt = o_sat[1]; qz_nxt = o_sat[2];
      end
      BR_M00: begin
        qw_nxt = o_sat[0]; qx_nxt = p_sat;    qy_nxt = o_sat[1]; qz_nxt = o_sat[2];
      end
      BR_M11: begin
        qw_nxt = o_sat[0]; qx_nxt = o_sat[1]; qy_nxt = p_sat;    qz_nxt = o_sat[2];
      end
      default: begin
        qw_nxt = o_sat[0]; qx_nxt = o_sat[1]; qy_nxt = o_sat[2]; qz_nxt = p_sat;
      end
    endcase
    if (dv_side.zero) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_side.valid;
      qw_r        <= qw_nxt;
      qx_r        <= qx_nxt;
      qy_r        <= qy_nxt;
      qz_r        <= qz_nxt;
      br_r        <= dv_side.br;
    end
  end

  assign out_quat.valid        = out_valid_r;
  assign out_quat.quat_w       = qw_r;
  assign out_quat.quat_x       = qx_r;
  assign out_quat.quat_y       = qy_r;
  assign out_quat.quat_z       = qz_r;
  assign out_quat.pivot_branch = br_r;

  // The pivot component is a square root and never negative.
  a_pivot_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      !((br_r == BR_TRACE && qw_r[QUAT_W-1]) || (br_r == BR_M00 && qx_r[QUAT_W-1]) ||
        (br_r == BR_M11 && qy_r[QUAT_W-1]) || (br_r == BR_M22 && qz_r[QUAT_W-1])))
    else $error("pivot component is negative");

  // A degenerate pivot zeroes all four components.
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && dv_side.valid && dv_side.zero) |=>
      (qw_r == 0 && qx_r == 0 && qy_r == 0 && qz_r == 0))
    else $error("degenerate pivot gave nonzero components");

  // No result is shown in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid_r)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

### rtl/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_isqrt import rmq_pkg::*; #(
  parameter int SQ = 15
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire side_t           in_side,
  input  wire logic [2*SQ-1:0] in_v,
  output side_t                out_side,
  output logic [SQ-1:0]        out_root
);

  localparam int VW = 2 * SQ;
  localparam int RW = SQ + 3;

  side_t           side_r [SQ];
  logic [RW-1:0]   rem_r  [SQ];
  logic [SQ-1:0]   root_r [SQ];
  logic [VW-1:0]   v_r    [SQ];

  side_t           s_in   [SQ];
  logic [RW-1:0]   rem_in [SQ];
  logic [SQ-1:0]   root_in[SQ];
  logic [VW-1:0]   v_in   [SQ];
  logic [RW-1:0]   cur    [SQ];
  logic [RW-1:0]   trial  [SQ];
  logic            ge     [SQ];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      if (k == 0) begin
        s_in[k]    = in_side;
        rem_in[k]  = '0;
        root_in[k] = '0;
        v_in[k]    = in_v;
      end else begin
        s_in[k]    = side_r[k-1];
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
        v_in[k]    = v_r[k-1];
      end
      cur[k]   = {rem_in[k][RW-3:0], v_in[k][VW-1:VW-2]};
      trial[k] = RW'({root_in[k], 2'b01});
      ge[k]    = (cur[k] >= trial[k]);
    end
  end

  // Stage registers advance together when the pipeline is enabled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ; k++) begin
        side_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < SQ; k++) begin
        side_r[k] <= s_in[k];
        rem_r[k]  <= ge[k] ? (cur[k] - trial[k]) : cur[k];
        root_r[k] <= {root_in[k][SQ-2:0], ge[k]};
        v_r[k]    <= {v_in[k][VW-3:0], 2'b00};
      end
    end
  end

  assign out_side = side_r[SQ-1];
  assign out_root = root_r[SQ-1];

endmodule

`default_nettype wire

### rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined rounding divider: n * 2^F / (4p), one quotient bit per
// stage, with an overflow flag for quotients too large for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div import rmq_pkg::*; #(
  parameter int F  = FRAC_BITS_DEF,
  parameter int SQ = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire side_t         in_side,
  input  wire logic [SQ-1:0] in_p,
  output side_t              out_side,
  output logic [SQ-1:0]      out_p,
  output logic [QUO_BITS-1:0] out_q   [3],
  output logic               out_neg [3],
  output logic               out_ovf [3]
);

  localparam int NW  = DIFF_W + F + 1;
  localparam int CW0 = (NW > SQ + 2 + QUO_BITS) ? NW : SQ + 2 + QUO_BITS;
  localparam int CW  = CW0 + 1;
  localparam int NS  = QUO_BITS + 1;

  side_t               side_r [NS];
  logic [SQ-1:0]       p_r    [NS];
  logic [CW-1:0]       rem_r  [NS][3];
  logic [QUO_BITS-1:0] q_r    [NS][3];
  logic                neg_r  [NS][3];
  logic                ovf_r  [NS][3];

  logic signed [DIFF_W-1:0] n_in [3];
  logic [DIFF_W-1:0]        mag  [3];
  logic [CW-1:0]            num  [3];
  logic [CW-1:0]            dsh0;
  logic [CW-1:0]            dsh  [NS];
  logic                     ge   [NS][3];

  // Prep stage: magnitude, rounding bias and overflow check.
  always_comb begin
    n_in[0] = in_side.n0;
    n_in[1] = in_side.n1;
    n_in[2] = in_side.n2;
    dsh0    = CW'({in_p, 2'b00}) << QUO_BITS;
    for (int l = 0; l < 3; l++) begin
      mag[l] = n_in[l][DIFF_W-1] ? (~n_in[l] + DIFF_W'(1)) : n_in[l];
      num[l] = (CW'(mag[l]) << F) + CW'({in_p, 1'b0});
    end
  end

  // Division steps: stage j resolves quotient bit QUO_BITS-j.
  always_comb begin
    dsh[0] = '0;
    for (int l = 0; l < 3; l++) begin
      ge[0][l] = 1'b0;
    end
    for (int j = 1; j < NS; j++) begin
      dsh[j] = CW'({p_r[j-1], 2'b00}) << (QUO_BITS - j);
      for (int l = 0; l < 3; l++) begin
        ge[j][l] = (rem_r[j-1][l] >= dsh[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) begin
        side_r[j].valid <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= in_side;
      p_r[0]    <= in_p;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= num[l];
        q_r[0][l]   <= '0;
        neg_r[0][l] <= n_in[l][DIFF_W-1];
        ovf_r[0][l] <= (num[l] >= dsh0);
      end
      for (int j = 1; j < NS; j++) begin
        side_r[j] <= side_r[j-1];
        p_r[j]    <= p_r[j-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[j][l] <= ge[j][l] ? (rem_r[j-1][l] - dsh[j]) : rem_r[j-1][l];
          q_r[j][l]   <= {q_r[j-1][l][QUO_BITS-2:0], ge[j][l]};
          neg_r[j][l] <= neg_r[j-1][l];
          ovf_r[j][l] <= ovf_r[j-1][l];
        end
      end
    end
  end

  always_comb begin
    out_side = side_r[NS-1];
    out_p    = p_r[NS-1];
    for (int l = 0; l < 3; l++) begin
      out_q[l]   = q_r[NS-1][l];
      out_neg[l] = neg_r[NS-1][l];
      out_ovf[l] = ovf_r[NS-1][l];
    end
  end

endmodule

`default_nettype wire
